[src/ssft_pkg.sv]
`timescale 1ns / 1ps

package ssft_pkg;

   localparam int DIVIDER_WIDTH = 8;
   localparam int CFG_WIDTH = 8;
   localparam int CMP_WIDTH = (DIVIDER_WIDTH > CFG_WIDTH) ? DIVIDER_WIDTH : CFG_WIDTH;
   localparam int FRAME_WIDTH = 12;

   localparam logic [CFG_WIDTH-1:0] HALF_PERIOD_RESET = 8'd80;
   localparam logic [DIVIDER_WIDTH-1:0] DIV_MAX = {DIVIDER_WIDTH{1'b1}};

   localparam logic [15:0] NIBBLE_PARITY_TABLE = 16'h6996;
   localparam logic [FRAME_WIDTH-1:0] STOP_BITS = 12'hC00;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   localparam logic REG_HALF_PERIOD = 1'b0;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       odd_parity;
   } item_type;

   typedef struct packed {
      logic serial_clock;
      logic serial_data;
      logic busy_res;
      logic load_accepted;
   } result_type;

   function automatic logic [FRAME_WIDTH-1:0] build_frame(input logic [7:0] data_byte,
                                                          input logic odd);
      logic [3:0] nib;
      logic       par;
      nib = data_byte[3:0] ^ data_byte[7:4];
      par = NIBBLE_PARITY_TABLE[nib] ^ odd;
      return STOP_BITS | {2'b00, par, data_byte, 1'b0};
   endfunction

endpackage

[src/ssft_csr.sv]
`timescale 1ns / 1ps

module ssft_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [2:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   output logic [ssft_pkg::CFG_WIDTH-1:0] half_period
);

   logic [ssft_pkg::CFG_WIDTH-1:0] half_period_ff;
   logic                           write_en;

   assign csr_pready = 1'b1;
   assign write_en = csr_psel && csr_penable && csr_pwrite
                     && (csr_paddr[2] == ssft_pkg::REG_HALF_PERIOD);

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= ssft_pkg::HALF_PERIOD_RESET;
      end else if (write_en) begin
         half_period_ff <= csr_pwdata[ssft_pkg::CFG_WIDTH-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == ssft_pkg::REG_HALF_PERIOD) begin
         csr_prdata[ssft_pkg::CFG_WIDTH-1:0] = half_period_ff;
      end
   end

   assign half_period = half_period_ff;

endmodule

[src/ssft_engine.sv]
`timescale 1ns / 1ps

module ssft_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_fire,
   input  ssft_pkg::item_type             item,
   input  logic [ssft_pkg::CFG_WIDTH-1:0] half_period,
   output ssft_pkg::result_type           result
);

   logic [ssft_pkg::DIVIDER_WIDTH-1:0] div_ff, div_in;
   logic                               clk_ff, clk_in;
   logic                               data_ff, data_in;
   logic [ssft_pkg::FRAME_WIDTH-1:0]   frame_ff, frame_in;
   logic                               accepted;
   logic [ssft_pkg::CMP_WIDTH-1:0]     cfg_wide;
   logic [ssft_pkg::CMP_WIDTH-1:0]     max_wide;
   logic [ssft_pkg::CMP_WIDTH-1:0]     div_wide;
   logic [ssft_pkg::CMP_WIDTH-1:0]     terminal;

   assign cfg_wide = ssft_pkg::CMP_WIDTH'(half_period);
   assign max_wide = ssft_pkg::CMP_WIDTH'(ssft_pkg::DIV_MAX);
   assign div_wide = ssft_pkg::CMP_WIDTH'(div_ff);
   assign terminal = (cfg_wide > max_wide) ? max_wide : cfg_wide;

   always_comb begin
      div_in   = div_ff;
      clk_in   = clk_ff;
      data_in  = data_ff;
      frame_in = frame_ff;
      accepted = 1'b0;
      unique case (item.kind)
         ssft_pkg::KIND_TICK: begin
            if (div_wide >= terminal) begin
               div_in = '0;
               clk_in = ~clk_ff;
               if (clk_in && (frame_ff != '0)) begin
                  data_in  = frame_ff[0];
                  frame_in = frame_ff >> 1;
               end
            end else begin
               div_in = div_ff + 1'b1;
            end
         end
         ssft_pkg::KIND_LOAD: begin
            if (frame_ff == '0) begin
               frame_in = ssft_pkg::build_frame(item.data_byte, item.odd_parity);
               accepted = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff   <= '0;
         clk_ff   <= 1'b0;
         data_ff  <= 1'b1;
         frame_ff <= '0;
      end else if (step_fire) begin
         div_ff   <= div_in;
         clk_ff   <= clk_in;
         data_ff  <= data_in;
         frame_ff <= frame_in;
      end
   end

   assign result.serial_clock  = clk_in;
   assign result.serial_data   = data_in;
   assign result.busy_res      = (frame_in != '0);
   assign result.load_accepted = accepted;

endmodule

[src/sync_serial_frame_transmitter_top.sv]
`timescale 1ns / 1ps

// Sends bytes as 12-bit synchronous frames (start bit, eight data bits LSB first, parity,
// two stop bits) on a serial clock divided down from tick items. Every item, tick or load,
// returns exactly one result item. One item is taken per cycle while the result register is
// not stalled. An item passes through the input register, the single state-update stage
// and the result register before its result is presented; a stalled result register holds
// the pipeline back.
module sync_serial_frame_transmitter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte [7:0], odd_parity [8], zeros [15:9]
   input  logic        req_tuser,   // kind [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // serial_clock [0], serial_data [1], busy_res [2],
                                    // load_accepted [3], zeros [7:4]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   ssft_pkg::item_type             in_ff;
   logic                           in_valid_ff;
   ssft_pkg::result_type           out_ff;
   logic                           out_valid_ff;
   ssft_pkg::result_type           step_result;
   logic [ssft_pkg::CFG_WIDTH-1:0] half_period;
   logic                           advance;
   logic                           step_fire;

   assign advance    = !out_valid_ff || rsp_tready;
   assign step_fire  = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   ssft_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .half_period (half_period)
   );

   ssft_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step_fire   (step_fire),
      .item        (in_ff),
      .half_period (half_period),
      .result      (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (step_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.kind       <= req_tuser;
         in_ff.data_byte  <= req_tdata[7:0];
         in_ff.odd_parity <= req_tdata[8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         out_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff.load_accepted, out_ff.busy_res,
                        out_ff.serial_data, out_ff.serial_clock};

endmodule

[src/ssft_checker.sv]
`timescale 1ns / 1ps

module ssft_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // The data line idles high whenever no frame is pending.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[2]) |-> rsp_tdata[1])
      else $error("data line low with no frame pending");

   // A taken load always leaves a frame pending.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |-> rsp_tdata[2])
      else $error("load taken but transmitter not busy");

   // No result leaves the block in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown straight after reset");

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // The input is only held off while a result waits to be taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a waiting result");

endmodule

bind sync_serial_frame_transmitter_top ssft_checker u_ssft_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/sv/sync_serial_frame_transmitter_top_tb.sv]
`timescale 1ns / 1ps

module sync_serial_frame_transmitter_top_tb;

   localparam int RESET_CYCLES = 6;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS = 10;
   localparam logic [2:0] ADDR_HALF_PERIOD = {ssft_pkg::REG_HALF_PERIOD, 2'b00};
   localparam logic [2:0] ADDR_UNUSED = 3'd4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = ssft_pkg::KIND_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [ssft_pkg::CFG_WIDTH-1:0]     half_period_m = ssft_pkg::HALF_PERIOD_RESET;
   logic [ssft_pkg::DIVIDER_WIDTH-1:0] divider_m = '0;
   logic                               clock_m = 1'b0;
   logic                               data_m = 1'b1;
   logic [ssft_pkg::FRAME_WIDTH-1:0]   shift_m = '0;

   ssft_pkg::result_type expected_lines[$];

   bit   tx_gaps_on = 1'b0;
   bit   rsp_gaps_on = 1'b0;
   logic hold_trigger = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   rsp_wait = 0;
   int   cycle_count = 0;
   int   n_items = 0;
   int   n_loads_taken = 0;
   int   n_loads_refused = 0;
   int   n_checked = 0;
   int   n_errors = 0;

   sync_serial_frame_transmitter_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_lines.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic ssft_pkg::result_type next_line_state(input ssft_pkg::item_type it);
      ssft_pkg::result_type               r;
      logic [ssft_pkg::DIVIDER_WIDTH-1:0] terminal;
      r.load_accepted = 1'b0;
      terminal = (ssft_pkg::CMP_WIDTH'(half_period_m) >
                  ssft_pkg::CMP_WIDTH'(ssft_pkg::DIV_MAX)) ?
                 ssft_pkg::DIV_MAX : ssft_pkg::DIVIDER_WIDTH'(half_period_m);
      if (it.kind == ssft_pkg::KIND_TICK) begin
         if (divider_m >= terminal) begin
            divider_m = '0;
            clock_m = ~clock_m;
            if (clock_m && shift_m != '0) begin
               data_m = shift_m[0];
               shift_m = shift_m >> 1;
            end
         end else begin
            divider_m = divider_m + 1'b1;
         end
      end else if (shift_m == '0) begin
         shift_m = {2'b11, (^it.data_byte) ^ it.odd_parity, it.data_byte, 1'b0};
         r.load_accepted = 1'b1;
      end
      r.serial_clock = clock_m;
      r.serial_data = data_m;
      r.busy_res = (shift_m != '0);
      return r;
   endfunction

   task automatic note_error(input string msg);
      n_errors++;
      if (n_errors <= MAX_REPORTS)
         $display("%s", msg);
   endtask

   always @(posedge clock) begin : rsp_side
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_tvalid && rsp_tready && rsp_gaps_on)
            rsp_wait = $urandom_range(0, 5);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (rsp_wait > 0) begin
            rsp_tready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_lines
      ssft_pkg::result_type got;
      ssft_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.serial_clock = rsp_tdata[0];
         got.serial_data = rsp_tdata[1];
         got.busy_res = rsp_tdata[2];
         got.load_accepted = rsp_tdata[3];
         if (expected_lines.size() == 0) begin
            note_error($sformatf("Unexpected result %b with nothing outstanding.",
                                 rsp_tdata));
         end else begin
            want = expected_lines.pop_front();
            n_checked++;
            if (got != want)
               note_error($sformatf({"Result %0d mismatch: expected clk=%b data=%b ",
                                     "busy=%b taken=%b, got clk=%b data=%b busy=%b ",
                                     "taken=%b"}, n_checked,
                                    want.serial_clock, want.serial_data,
                                    want.busy_res, want.load_accepted,
                                    got.serial_clock, got.serial_data,
                                    got.busy_res, got.load_accepted));
         end
      end
   end

   task automatic send_item(input ssft_pkg::item_type it);
      int                   gap;
      ssft_pkg::result_type line;
      gap = tx_gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, it.odd_parity, it.data_byte};
      req_tuser <= it.kind;
      do @(posedge clock); while (!req_tready);
      line = next_line_state(it);
      expected_lines.push_back(line);
      n_items++;
      if (it.kind == ssft_pkg::KIND_LOAD) begin
         if (line.load_accepted)
            n_loads_taken++;
         else
            n_loads_refused++;
      end
   endtask

   task automatic send_tick(input int count);
      ssft_pkg::item_type it;
      repeat (count) begin
         it.kind = ssft_pkg::KIND_TICK;
         it.data_byte = $urandom_range(0, 255);
         it.odd_parity = $urandom_range(0, 1);
         send_item(it);
      end
   endtask

   task automatic send_load(input logic [7:0] value, input logic odd);
      ssft_pkg::item_type it;
      it.kind = ssft_pkg::KIND_LOAD;
      it.data_byte = value;
      it.odd_parity = odd;
      send_item(it);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == ADDR_HALF_PERIOD)
         half_period_m = value[ssft_pkg::CFG_WIDTH-1:0];
   endtask

   task automatic csr_check(input logic [2:0] addr);
      logic [31:0] got;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got != 32'(half_period_m))
         note_error($sformatf("Register read mismatch: expected %0d, got %0d",
                              half_period_m, got));
   endtask

   task automatic test_reset_frames();
      send_tick(2);
      send_load(8'hA5, 1'b1);
      send_load(8'h3C, 1'b0);
      send_tick(1);
      wait_idle();
   endtask

   task automatic test_register_access();
      csr_check(ADDR_HALF_PERIOD);
      csr_write(ADDR_UNUSED, 32'd7);
      csr_check(ADDR_HALF_PERIOD);
      csr_write(ADDR_HALF_PERIOD, 32'd255);
      csr_check(ADDR_HALF_PERIOD);
      csr_write(ADDR_HALF_PERIOD, 32'd1);
      csr_check(ADDR_HALF_PERIOD);
   endtask

   task automatic test_fast_frames();
      csr_write(ADDR_HALF_PERIOD, 32'd0);
      send_load(8'hFF, 1'b1);
      send_tick(26);
      send_load(8'h00, 1'b0);
      send_load(8'h80, 1'b1);
      wait_idle();
   endtask

   task automatic test_random_phase(input logic [7:0] half, input int count,
                                    input bit gaps);
      ssft_pkg::item_type it;
      csr_write(ADDR_HALF_PERIOD, 32'(half));
      tx_gaps_on = gaps;
      rsp_gaps_on = gaps;
      repeat (count) begin
         if (shift_m == '0)
            it.kind = ($urandom_range(0, 9) < 4) ? ssft_pkg::KIND_LOAD : ssft_pkg::KIND_TICK;
         else
            it.kind = ($urandom_range(0, 19) == 0) ? ssft_pkg::KIND_LOAD
                                                   : ssft_pkg::KIND_TICK;
         it.data_byte = $urandom_range(0, 255);
         it.odd_parity = $urandom_range(0, 1);
         send_item(it);
      end
      wait_idle();
   endtask

   task automatic test_back_pressure();
      ssft_pkg::item_type it;
      csr_write(ADDR_HALF_PERIOD, 32'd0);
      tx_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      hold_trigger <= ~hold_trigger;
      repeat (150) begin
         it.kind = (shift_m == '0) ? ssft_pkg::KIND_LOAD : ssft_pkg::KIND_TICK;
         it.data_byte = $urandom_range(0, 255);
         it.odd_parity = $urandom_range(0, 1);
         send_item(it);
      end
      wait_idle();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_frames();
      test_register_access();
      test_fast_frames();
      test_random_phase(8'd0, 250, 1'b1);
      test_random_phase(8'd1, 200, 1'b1);
      test_random_phase(8'd3, 200, 1'b1);
      test_random_phase(8'd255, 300, 1'b1);
      test_random_phase(8'd2, 150, 1'b0);
      test_back_pressure();
      $display("Sent %0d items: %0d loads taken, %0d loads refused while busy.",
               n_items, n_loads_taken, n_loads_refused);
      $display("Checked %0d results over divider settings 0 to 255 and a long output stall.",
               n_checked);
      if (n_errors == 0 && expected_lines.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
